// ===== sv/bkit_pkg.sv =====
package bkit_pkg;

	localparam int NumW       = 64;
	localparam int Digits     = NumW / 2;
	localparam int MaxDigits  = 32;
	localparam int IdxW       = 8;
	localparam int StepW      = IdxW + 1;
	localparam int IndexCap   = 255;
	localparam int CntW       = $clog2(Digits + 1);
	localparam int ScanW      = $clog2(Digits);
	localparam int SumW       = NumW + 1;

	typedef struct packed {
		logic load;
		logic scan;
		logic run;
		logic store;
	} bkit_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic run_done;
	} bkit_sts_t;

endpackage

// ===== sv/base4_keith_index_test.sv =====
// Base-4 Keith number index test.
// Input channel: number with number_valid / number_ready. A transaction is
// taken only while the block is idle; one number is worked on at a time.
// Output channel: hit_position and is_keith with result_valid / result_ready,
// one result transaction per input transaction, held in an output register.
// Steps: the number is loaded as it is taken, then a digit scan of every
// base-4 digit (one per cycle from the top, skipping leading zeros and
// filling the term window), then one recurrence term per cycle until a term
// reaches the number, then the result is stored.
// The recurrence loop (one 65-bit add, subtract and compare per cycle) sets
// the throughput; a new number is taken the cycle after the result is stored.
// A stalled receiver holds the result register; the next number may still be
// taken and worked on, but its result waits until the register is freed.
// Reset clears the controller and the output valid; no clearing pass is run.
module base4_keith_index_test
	import bkit_pkg::*;
#(
	parameter int MAX_DIGITS = MaxDigits
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            number_valid,
	output logic            number_ready,
	input  logic [NumW-1:0] number,
	output logic            result_valid,
	input  logic            result_ready,
	output logic [IdxW-1:0] hit_position,
	output logic            is_keith
);

	bkit_cmd_t cmd;
	bkit_sts_t sts;

	bkit_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.number_valid (number_valid),
		.number_ready (number_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	bkit_dp #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.number       (number),
		.cmd          (cmd),
		.sts          (sts),
		.hit_position (hit_position),
		.is_keith     (is_keith)
	);

`ifndef ASSERT_OFF
	a_flag_matches: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (is_keith == (hit_position != '0)))
		else $error("is_keith disagrees with hit_position");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.scan, cmd.run, cmd.store}))
		else $error("more than one datapath command at once");

	a_store_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |=> result_valid)
		else $error("stored result not presented");

	a_busy_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan || cmd.run) |-> !number_ready)
		else $error("input taken while working");
`endif

endmodule

// ===== sv/bkit_ctrl.sv =====
module bkit_ctrl
	import bkit_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      number_valid,
	output logic      number_ready,
	output logic      result_valid,
	input  logic      result_ready,
	input  bkit_sts_t sts,
	output bkit_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RUN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free     = !out_valid_q || result_ready;
	assign number_ready = (state_q == ST_IDLE);
	assign result_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: cmd.load = number_valid;
			ST_SCAN: cmd.scan = 1'b1;
			ST_RUN: begin
				cmd.run   = !sts.run_done;
				cmd.store = sts.run_done && out_free;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (number_valid) state_q <= ST_SCAN;
				ST_SCAN: if (sts.scan_last) state_q <= ST_RUN;
				ST_RUN:  if (sts.run_done && out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.store) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/bkit_dp.sv =====
module bkit_dp
	import bkit_pkg::*;
#(
	parameter int MAX_DIGITS = MaxDigits
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [NumW-1:0] number,
	input  bkit_cmd_t       cmd,
	output bkit_sts_t       sts,
	output logic [IdxW-1:0] hit_position,
	output logic            is_keith
);

	localparam int PtrW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

	logic [NumW-1:0]  win_q [MAX_DIGITS];
	logic [NumW-1:0]  num_q;
	logic [NumW-1:0]  v_q;
	logic [SumW-1:0]  sum_q;
	logic [CntW-1:0]  cnt_q;
	logic [ScanW-1:0] scan_q;
	logic [PtrW-1:0]  head_q;
	logic [StepW-1:0] idx_q;
	logic [IdxW-1:0]  hit_q;
	logic             keith_q;

	logic [1:0]       digit;
	logic             take;
	logic [StepW-1:0] idx_next;
	logic             bad_k;
	logic             reached;
	logic             done;
	logic [IdxW-1:0]  res;
	logic [NumW-1:0]  oldest;

	assign digit    = v_q[NumW-1 -: 2];
	assign take     = (cnt_q != '0) || (digit != 2'd0);
	assign idx_next = idx_q + StepW'(1);
	assign bad_k    = (cnt_q < CntW'(2)) || (cnt_q > CntW'(MAX_DIGITS));
	assign reached  = (sum_q[NumW-1:0] >= num_q);
	assign oldest   = win_q[head_q];

	always_comb begin
		done = 1'b1;
		res  = '0;
		if (bad_k || (idx_next > StepW'(IndexCap)) || sum_q[SumW-1]) begin
			res = '0;
		end else if (reached) begin
			res = (sum_q[NumW-1:0] == num_q) ? idx_next[IdxW-1:0] : '0;
		end else begin
			done = 1'b0;
		end
	end

	assign sts.scan_last = (scan_q == ScanW'(Digits - 1));
	assign sts.run_done  = done;
	assign hit_position  = hit_q;
	assign is_keith      = keith_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			scan_q <= '0;
			head_q <= '0;
			idx_q  <= '0;
		end else begin
			if (cmd.load) begin
				cnt_q  <= '0;
				scan_q <= '0;
				head_q <= '0;
			end
			if (cmd.scan) begin
				scan_q <= scan_q + ScanW'(1);
				if (take) cnt_q <= cnt_q + CntW'(1);
				idx_q <= StepW'(cnt_q) + StepW'(take);
			end
			if (cmd.run) begin
				idx_q  <= idx_next;
				head_q <= (CntW'(head_q) == cnt_q - CntW'(1)) ? '0 : head_q + PtrW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q <= number;
			v_q   <= number;
			sum_q <= '0;
		end
		if (cmd.scan) begin
			v_q <= {v_q[NumW-3:0], 2'b00};
			if (take) begin
				sum_q <= sum_q + SumW'(digit);
				if (cnt_q < CntW'(MAX_DIGITS)) win_q[cnt_q[PtrW-1:0]] <= NumW'(digit);
			end
		end
		if (cmd.run) begin
			sum_q          <= {sum_q[NumW-1:0], 1'b0} - {1'b0, oldest};
			win_q[head_q]  <= sum_q[NumW-1:0];
		end
		if (cmd.store) begin
			hit_q   <= res;
			keith_q <= (res != '0);
		end
	end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import bkit_pkg::*;

	typedef struct packed {
		logic [IdxW-1:0] pos;
		logic            keith;
	} hit_t;

	typedef struct {
		logic [NumW-1:0] num;
		bit              typed;
		logic [IdxW-1:0] pos;
	} stim_row_t;

	localparam int RandomItems = 634;

	logic            clk          = 1'b0;
	logic            arst_n       = 1'b0;
	logic            number_valid = 1'b0;
	logic            number_ready;
	logic [NumW-1:0] number       = '0;
	logic            result_valid;
	logic            result_ready = 1'b0;
	logic [IdxW-1:0] hit_position;
	logic            is_keith;

	hit_t            pending_hits[$];
	logic [NumW-1:0] keith_list[$];
	int              mismatches = 0;
	int              stall_left = 0;
	bit              calm       = 1'b0;
	stim_row_t       directed[16];

	base4_keith_index_test dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.number_valid (number_valid),
		.number_ready (number_ready),
		.number       (number),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.hit_position (hit_position),
		.is_keith     (is_keith)
	);

	always #5 clk = ~clk;

	function automatic logic [IdxW-1:0] keith_hit_index(input logic [NumW-1:0] n);
		logic [1:0]      digs[Digits];
		logic [NumW-1:0] win[MaxDigits];
		logic [NumW-1:0] v;
		logic [SumW-1:0] sum;
		logic [SumW-1:0] term;
		int              k;
		int              idx;
		int              head;
		k   = 0;
		v   = n;
		sum = '0;
		while (v != 0 && k < Digits) begin
			digs[k] = v[1:0];
			k++;
			v = v >> 2;
		end
		if (k < 2 || k > MaxDigits)
			return '0;
		for (int i = 0; i < MaxDigits; i++)
			win[i] = '0;
		for (int i = 0; i < k; i++) begin
			win[i] = NumW'(digs[k-1-i]);
			sum    = sum + SumW'(win[i]);
		end
		idx  = k;
		head = 0;
		while (1) begin
			idx++;
			if (idx > IndexCap)
				return '0;
			if (sum[SumW-1])
				return '0;
			term = sum;
			if (term[NumW-1:0] >= n)
				return (term[NumW-1:0] == n) ? IdxW'(idx) : '0;
			sum       = sum + term - SumW'(win[head]);
			win[head] = term[NumW-1:0];
			head++;
			if (head >= k)
				head = 0;
		end
	endfunction

	function automatic hit_t predicted_hit(input logic [NumW-1:0] n);
		hit_t h;
		h.pos   = keith_hit_index(n);
		h.keith = (h.pos != 0);
		return h;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(30, 300);
	endfunction

	function automatic logic [NumW-1:0] random_number();
		logic [NumW-1:0] full;
		int              r;
		int              w;
		full = {$urandom, $urandom};
		r    = $urandom_range(0, 99);
		if (r < 30 && keith_list.size() != 0) begin
			full = keith_list[$urandom_range(0, keith_list.size() - 1)];
			if (r >= 24)
				full = full + NumW'($urandom_range(0, 2)) - 1;
			return full;
		end
		if (r < 40)
			return NumW'($urandom_range(0, 15));
		if (r < 60) begin
			w = $urandom_range(1, NumW);
			return full >> (NumW - w);
		end
		if (r < 72)
			return ~NumW'($urandom_range(0, 1000));
		return full;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	task automatic check_result();
		hit_t want;
		if (pending_hits.size() == 0) begin
			report_mismatch("unexpected result", hit_position, 0);
		end else begin
			want = pending_hits.pop_front();
			if (hit_position !== want.pos)
				report_mismatch("hit_position", hit_position, want.pos);
			if (is_keith !== want.keith)
				report_mismatch("is_keith", is_keith, want.keith);
		end
	endtask

	task automatic send_number(input logic [NumW-1:0] n, input hit_t want);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			number_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		number_valid <= 1'b1;
		number       <= n;
		do @(posedge clk); while (!number_ready);
		pending_hits.insert(pending_hits.size(), want);
	endtask

	task automatic drain_hits();
		while (pending_hits.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			check_result();
		if ($urandom_range(0, 199) == 0)
			calm = ~calm;
		if (stall_left > 0) begin
			result_ready <= 1'b0;
			stall_left--;
		end else begin
			result_ready <= 1'b1;
			if (!calm && $urandom_range(0, 99) < 25)
				stall_left = ($urandom_range(0, 99) < 8) ? $urandom_range(50, 300)
				                                         : $urandom_range(1, 4);
		end
	end

	initial begin
		#20_000_000;
		$display("tb_top failed");
		$finish;
	end

	initial begin
		hit_t want;
		directed = '{
			'{64'd0,                  1'b1, 8'd0},
			'{64'd1,                  1'b1, 8'd0},
			'{64'd2,                  1'b1, 8'd0},
			'{64'd3,                  1'b1, 8'd0},
			'{64'd7,                  1'b1, 8'd4},
			'{64'd4,                  1'b0, 8'd0},
			'{64'd15,                 1'b0, 8'd0},
			'{64'd16,                 1'b0, 8'd0},
			'{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'd0},
			'{64'h8000_0000_0000_0000, 1'b0, 8'd0},
			'{64'h4000_0000_0000_0000, 1'b0, 8'd0},
			'{64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 8'd0},
			'{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 8'd0},
			'{64'h5555_5555_5555_5555, 1'b0, 8'd0},
			'{64'h0000_0000_FFFF_FFFF, 1'b0, 8'd0},
			'{64'hFFFF_FFFF_0000_0000, 1'b0, 8'd0}
		};
		for (int n = 4; n < 65536; n++)
			if (keith_hit_index(NumW'(n)) != 0)
				keith_list.insert(keith_list.size(), NumW'(n));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].typed) begin
				want.pos   = directed[i].pos;
				want.keith = (directed[i].pos != 0);
			end else begin
				want = predicted_hit(directed[i].num);
			end
			send_number(directed[i].num, want);
		end

		number_valid <= 1'b0;
		drain_hits();

		for (int i = 0; i < RandomItems; i++) begin
			logic [NumW-1:0] n;
			if (i == 200 || i == 420) begin
				number_valid <= 1'b0;
				drain_hits();
				@(posedge clk);
			end
			n = random_number();
			send_number(n, predicted_hit(n));
		end
		number_valid <= 1'b0;

		drain_hits();
		repeat (150) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
